>>> design/gbf_pkg.sv
package gbf_pkg;

    // Frame limits and weight format
    localparam int MAX_WIDTH        = 1024;
    localparam int MAX_HEIGHT       = 1024;
    localparam int MAX_RADIUS       = 6;
    localparam int WEIGHT_FRAC_BITS = 16;

    // Row store: a ring of rows, one row cell per ring slot
    localparam int RING_ROWS = 3 * MAX_RADIUS + 1;
    localparam int RING_W    = $clog2(RING_ROWS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);

    // Fixed field widths
    localparam int DIM_W     = 11;
    localparam int RAD_W     = 3;
    localparam int WNEAR_W   = 64;
    localparam int WFAR_W    = 48;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_IDX_W = 3;
    localparam int DIST_W    = 4;

    // Datapath widths
    localparam int PMUL_W     = CH_W + WEIGHT_FRAC_BITS;
    localparam int PROD_W     = CH_W + 2 * WEIGHT_FRAC_BITS;
    localparam int CELL_ACC_W = PROD_W + $clog2(2 * MAX_RADIUS + 1);
    localparam int SUM_W      = PROD_W + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_NEAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_FAR  = 3'd4;

    typedef logic [2:0][CELL_ACC_W-1:0] gbf_acc_t;

    // Broadcast control from the sequencer to every row cell
    typedef struct packed {
        logic                        wr_en;
        logic [RING_W-1:0]           wr_ring;
        logic [COL_W-1:0]            wr_addr;
        logic [PIX_W-1:0]            wr_data;
        logic                        rd_en;
        logic [COL_W-1:0]            rd_addr;
        logic [WEIGHT_FRAC_BITS-1:0] wx;
        logic                        acc_en;
        logic                        load;
        logic                        shift;
        logic [RING_W-1:0]           out_ring;
        logic [ROW_W-1:0]            out_row;
        logic [DIM_W-1:0]            height;
        logic [RAD_W-1:0]            radius;
        logic [WNEAR_W-1:0]          wnear;
        logic [WFAR_W-1:0]           wfar;
    } gbf_ctl_t;

    // 1D weight for a tap distance; distances past the table weigh zero
    function automatic logic [WEIGHT_FRAC_BITS-1:0] tap_weight(
        input logic [WNEAR_W-1:0] wn,
        input logic [WFAR_W-1:0]  wf,
        input logic [DIST_W-1:0]  d
    );
        logic [15:0] raw;
        unique case (d)
            4'd0:    raw = wn[15:0];
            4'd1:    raw = wn[31:16];
            4'd2:    raw = wn[47:32];
            4'd3:    raw = wn[63:48];
            4'd4:    raw = wf[15:0];
            4'd5:    raw = wf[31:16];
            4'd6:    raw = wf[47:32];
            default: raw = '0;
        endcase
        return raw[WEIGHT_FRAC_BITS-1:0];
    endfunction

endpackage

>>> design/gbf_ram.sv
module gbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/gbf_cell.sv
module gbf_cell
    import gbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RING_W-1:0] ring_idx,
    input  gbf_ctl_t          ctl,
    input  gbf_acc_t          acc_in,
    output gbf_acc_t          acc_out
);

    logic [PIX_W-1:0]              rd_data;
    logic [WEIGHT_FRAC_BITS-1:0]   wy_reg, wy_next;
    logic                          row_on_reg, row_on_next;
    logic [2:0][PMUL_W-1:0]        mulb_reg, mulb_next;
    logic [2:0][PROD_W-1:0]        mulc_reg, mulc_next;
    gbf_acc_t                      acc_reg, acc_next;
    logic [RING_W-1:0]             fwd_dist, back_dist;
    logic [ROW_W:0]                fwd_row;
    logic                          fwd_ok, back_ok;
    logic [DIST_W-1:0]             row_dist;

    // One row of the ring lives in this cell
    gbf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_row (
        .clk  (clk),
        .we   (ctl.wr_en && (ctl.wr_ring == ring_idx)),
        .waddr(ctl.wr_addr),
        .wdata(ctl.wr_data),
        .re   (ctl.rd_en),
        .raddr(ctl.rd_addr),
        .rdata(rd_data)
    );

    // Find which window row this slot holds and its row weight
    always_comb
    begin
        if (ring_idx >= ctl.out_ring)
        begin
            fwd_dist = ring_idx - ctl.out_ring;
        end
        else
        begin
            fwd_dist = ring_idx + RING_W'(RING_ROWS) - ctl.out_ring;
        end
        back_dist = RING_W'(RING_ROWS) - fwd_dist;
        fwd_row   = {1'b0, ctl.out_row} + (ROW_W + 1)'(fwd_dist);
        fwd_ok    = ({2'b0, fwd_dist} <= (RING_W + 2)'(ctl.radius))
                    && (fwd_row < (ROW_W + 1)'(ctl.height));
        back_ok   = ({2'b0, back_dist} <= (RING_W + 2)'(ctl.radius))
                    && (ctl.out_row >= ROW_W'(back_dist));
        row_dist  = fwd_ok ? DIST_W'(fwd_dist) : DIST_W'(back_dist);
        wy_next   = wy_reg;
        row_on_next = row_on_reg;
        if (ctl.load)
        begin
            wy_next = (fwd_ok || back_ok) ? tap_weight(ctl.wnear, ctl.wfar, row_dist) : '0;
            row_on_next = fwd_ok || back_ok;
        end
    end

    // Weight each channel by row, then column, then accumulate or shift out
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mulb_next[c] = PMUL_W'(rd_data[CH_W*c +: CH_W]) * PMUL_W'(wy_reg);
            mulc_next[c] = PROD_W'(mulb_reg[c]) * PROD_W'(ctl.wx);
        end
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = '0;
        end
        else if (ctl.shift)
        begin
            acc_next = acc_in;
        end
        else if (ctl.acc_en && row_on_reg)
        begin
            // rows outside the window are skipped, their slots may be stale
            for (int c = 0; c < 3; c++)
            begin
                acc_next[c] = acc_reg[c] + CELL_ACC_W'(mulc_reg[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            row_on_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            row_on_reg <= row_on_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        wy_reg   <= wy_next;
        mulb_reg <= mulb_next;
        mulc_reg <= mulc_next;
    end

    assign acc_out = acc_reg;

endmodule

>>> design/gaussian_blur_filter.sv
// Streaming Gaussian blur for RGB frames in raster order. Each pixel word is
// written into a ring of 19 row cells (one line store per cell); a pixel that
// completes a window position starts one output. The window is swept one
// column per cycle across all row cells at once, then the per-row sums are
// unloaded through the cell chain into the final adder. No new pixel is taken
// while an output is being computed or waits for the output register. Drain
// words (tuser = 1) push out the outputs still pending at the end of a frame.
// The line stores are not cleared after reset; every accumulated read hits a
// location written earlier in the same frame.
module gaussian_blur_filter
    import gbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WNEAR_W-1:0]   cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    input  logic                 s_axis_tuser,  // command
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,  // out_red, out_green, out_blue
    output logic                 m_axis_tlast
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [DIM_W-1:0]            width_reg, width_next;
    logic [DIM_W-1:0]            height_reg, height_next;
    logic [RAD_W-1:0]            radius_reg, radius_next;
    logic [WNEAR_W-1:0]          wnear_reg, wnear_next;
    logic [WFAR_W-1:0]           wfar_reg, wfar_next;
    logic [COL_W-1:0]            in_col_reg, in_col_next;
    logic [ROW_W-1:0]            in_row_reg, in_row_next;
    logic [RING_W-1:0]           in_ring_reg, in_ring_next;
    logic [COL_W-1:0]            out_col_reg, out_col_next;
    logic [ROW_W-1:0]            out_row_reg, out_row_next;
    logic [RING_W-1:0]           out_ring_reg, out_ring_next;
    logic [COL_W-1:0]            x_reg, x_next;
    logic [COL_W-1:0]            x_end_reg, x_end_next;
    logic [WEIGHT_FRAC_BITS-1:0] wx1_reg, wx2_reg;
    logic                        v1_reg, v2_reg, v3_reg;
    logic [RING_W-1:0]           shift_cnt_reg, shift_cnt_next;
    logic [2:0][SUM_W-1:0]       total_reg, total_next;
    logic                        out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]            out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic [DIM_W-1:0]            w_eff, h_eff;
    logic [RAD_W-1:0]            r_eff;
    logic                        in_acc, cfg_acc, row_in_frame, lag_hit, last_out;
    logic [2*DIM_W-1:0]          in_pos, lag_pos;
    logic [DIM_W-1:0]            col_inc, c1_sum;
    logic [COL_W-1:0]            c0, c1, dx;
    logic [WEIGHT_FRAC_BITS-1:0] wx0;
    logic [15:0]                 ch_int;
    gbf_ctl_t                    ctl;
    gbf_acc_t                    chain [RING_ROWS+1];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = cfg_valid && cfg_ready;

    // Clamp geometry registers to their working range
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
        r_eff = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
    end

    // Window position checks and column bounds
    always_comb
    begin
        row_in_frame = (ROW_W + 1)'(in_row_reg) < (ROW_W + 1)'(h_eff);
        // linear input position against the output lag of radius rows plus radius pixels
        in_pos       = (2*DIM_W)'(in_row_reg) * (2*DIM_W)'(w_eff) + (2*DIM_W)'(in_col_reg);
        lag_pos      = (2*DIM_W)'(r_eff) * (2*DIM_W)'(w_eff) + (2*DIM_W)'(r_eff);
        lag_hit      = (in_pos >= lag_pos);
        col_inc      = DIM_W'(in_col_reg) + DIM_W'(1);
        c0           = (out_col_reg > COL_W'(r_eff)) ? out_col_reg - COL_W'(r_eff) : '0;
        c1_sum       = DIM_W'(out_col_reg) + DIM_W'(r_eff);
        c1           = (c1_sum < w_eff - DIM_W'(1)) ? COL_W'(c1_sum) : COL_W'(w_eff - DIM_W'(1));
        dx           = (x_reg >= out_col_reg) ? x_reg - out_col_reg : out_col_reg - x_reg;
        wx0          = tap_weight(wnear_reg, wfar_reg, DIST_W'(dx));
        last_out     = ((ROW_W + 1)'(out_row_reg) >= (ROW_W + 1)'(h_eff) - (ROW_W + 1)'(1))
                       && (DIM_W'(out_col_reg) >= w_eff - DIM_W'(1));
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        radius_next    = radius_reg;
        wnear_next     = wnear_reg;
        wfar_next      = wfar_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_ring_next   = in_ring_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_ring_next  = out_ring_reg;
        x_next         = x_reg;
        x_end_next     = x_end_reg;
        shift_cnt_next = shift_cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ch_int         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // drop drain words that arrive inside the frame
                if (in_acc && !(row_in_frame && s_axis_tuser))
                begin
                    if (col_inc >= w_eff)
                    begin
                        in_col_next  = '0;
                        in_row_next  = in_row_reg + ROW_W'(1);
                        in_ring_next = (in_ring_reg == RING_W'(RING_ROWS - 1))
                                       ? '0 : in_ring_reg + RING_W'(1);
                    end
                    else
                    begin
                        in_col_next = COL_W'(col_inc);
                    end
                    if (lag_hit)
                    begin
                        state_next = ST_SWEEP;
                        x_next     = c0;
                        x_end_next = c1;
                        total_next = '0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (x_reg == x_end_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    x_next = x_reg + COL_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!(v1_reg || v2_reg || v3_reg))
                begin
                    state_next     = ST_SHIFT;
                    shift_cnt_next = '0;
                end
            end
            ST_SHIFT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    total_next[c] = total_reg[c] + SUM_W'(chain[0][c]);
                end
                if (shift_cnt_reg == RING_W'(RING_ROWS - 1))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    shift_cnt_next = shift_cnt_reg + RING_W'(1);
                end
            end
            ST_RESULT:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = last_out;
                    for (int c = 0; c < 3; c++)
                    begin
                        ch_int = total_reg[c][2*WEIGHT_FRAC_BITS +: 16];
                        out_data_next[CH_W*c +: CH_W] = (ch_int[15:8] != '0)
                                                        ? '1 : ch_int[7:0];
                    end
                    if (last_out)
                    begin
                        in_col_next   = '0;
                        in_row_next   = '0;
                        in_ring_next  = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        out_ring_next = '0;
                    end
                    else if (DIM_W'(out_col_reg) + DIM_W'(1) >= w_eff)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + ROW_W'(1);
                        out_ring_next = (out_ring_reg == RING_W'(RING_ROWS - 1))
                                        ? '0 : out_ring_reg + RING_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes; geometry writes restart the frame
        if (cfg_acc)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[DIM_W-1:0];
                REG_BLUR_RADIUS:  radius_next = cfg_data[RAD_W-1:0];
                REG_WEIGHTS_NEAR: wnear_next  = cfg_data;
                REG_WEIGHTS_FAR:  wfar_next   = cfg_data[WFAR_W-1:0];
                default:          ;
            endcase
            if ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT)
                || (cfg_index == REG_BLUR_RADIUS))
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_ring_next  = '0;
                out_col_next  = '0;
                out_row_next  = '0;
                out_ring_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= DIM_W'(640);
            height_reg    <= DIM_W'(480);
            radius_reg    <= RAD_W'(3);
            wnear_reg     <= '0;
            wfar_reg      <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_ring_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            shift_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            radius_reg    <= radius_next;
            wnear_reg     <= wnear_next;
            wfar_reg      <= wfar_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_ring_reg   <= in_ring_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_ring_reg  <= out_ring_next;
            v1_reg        <= (state_reg == ST_SWEEP);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            shift_cnt_reg <= shift_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        x_end_reg    <= x_end_next;
        wx1_reg      <= wx0;
        wx2_reg      <= wx1_reg;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Broadcast to the row cells
    always_comb
    begin
        ctl.wr_en    = in_acc && row_in_frame && !s_axis_tuser;
        ctl.wr_ring  = in_ring_reg;
        ctl.wr_addr  = in_col_reg;
        ctl.wr_data  = s_axis_tdata;
        ctl.rd_en    = (state_reg == ST_SWEEP);
        ctl.rd_addr  = x_reg;
        ctl.wx       = wx2_reg;
        ctl.acc_en   = v3_reg;
        ctl.load     = in_acc && !(row_in_frame && s_axis_tuser) && lag_hit;
        ctl.shift    = (state_reg == ST_SHIFT);
        ctl.out_ring = out_ring_reg;
        ctl.out_row  = out_row_reg;
        ctl.height   = h_eff;
        ctl.radius   = r_eff;
        ctl.wnear    = wnear_reg;
        ctl.wfar     = wfar_reg;
    end

    // Chain of row cells; partial sums unload toward cell 0
    assign chain[RING_ROWS] = '0;

    for (genvar i = 0; i < RING_ROWS; i++)
    begin : g_cell
        gbf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ring_idx(RING_W'(i)),
            .ctl     (ctl),
            .acc_in  (chain[i+1]),
            .acc_out (chain[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (x_reg <= x_end_reg))
        else $error("column sweep ran past the window end");

    a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ring_reg < RING_W'(RING_ROWS)) && (out_ring_reg < RING_W'(RING_ROWS)))
        else $error("ring row index out of range");

    a_unload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("chain unload began with products still in flight");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_RESULT) && $stable(out_data_reg))
        else $error("result overwrote a word still waiting");
`endif

endmodule
